@@ rtl/core/tbvc_pkg.sv @@
// Package for the target bearing velocity command block.
// Constants, arctangent table and shared helpers; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tbvc_pkg;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int POS_WIDTH_DEF = 32;
   localparam int GUARD_BITS = 16;
   localparam int CFG_ADDR_WIDTH = 4;
   localparam logic [31:0] KINV_Q30 = 32'd652032874;

   localparam logic [1:0] REG_TARGET_X = 2'd0;
   localparam logic [1:0] REG_TARGET_Y = 2'd1;
   localparam logic [1:0] REG_SPEED_GAIN = 2'd2;
   localparam logic [1:0] REG_HEADING_GAIN = 2'd3;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] r;
      begin
         unique case (idx)
            5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
            5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
            5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
            5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001; default: r = 32'h00000000;
         endcase
         return r;
      end
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      logic signed [15:0] r;
      begin
         if (v > 64'sd32767) r = 16'sh7FFF;
         else if (v < -64'sd32768) r = -16'sh8000;
         else r = v[15:0];
         return r;
      end
   endfunction
endpackage
`default_nettype wire

@@ rtl/core/tbvc_if.sv @@
// Valid/ready channel interfaces for request and response beats.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface tbvc_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [15:0] heading;
   modport source (output valid, pos_x, pos_y, heading, input ready);
   modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface tbvc_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic signed [15:0] turn_rate;
   logic at_target;
   modport source (output valid, vel_x, vel_y, turn_rate, at_target, input ready);
   modport sink (input valid, vel_x, vel_y, turn_rate, at_target, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tbvc_cordic_stage.sv @@
// One registered micro-rotation of the vectoring and rotation CORDIC pair.
// Depends on tbvc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tbvc_cordic_stage
   import tbvc_pkg::*;
#(
   parameter int STAGE = 0,
   parameter int DW = 50,
   parameter int CW = 2 + 16 + 16 + 2 + 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic enable,
   input wire logic in_valid,
   input wire logic signed [DW-1:0] in_x,
   input wire logic signed [DW-1:0] in_y,
   input wire logic [31:0] in_z,
   input wire logic signed [34:0] in_vx,
   input wire logic signed [34:0] in_vy,
   input wire logic [CW-1:0] in_side,
   output logic out_valid,
   output logic signed [DW-1:0] out_x,
   output logic signed [DW-1:0] out_y,
   output logic [31:0] out_z,
   output logic signed [34:0] out_vx,
   output logic signed [34:0] out_vy,
   output logic [CW-1:0] out_side
);
   localparam logic [4:0] IDX = 5'(STAGE);
   logic valid_ff;
   logic signed [DW-1:0] x_ff, y_ff, x_in, y_in;
   logic [31:0] z_ff, z_in;
   logic signed [34:0] vx_ff, vy_ff, vx_in, vy_in;
   logic [CW-1:0] side_ff;

   always_comb begin
      if (in_y > 0) begin
         x_in = in_x + (in_y >>> STAGE);
         y_in = in_y - (in_x >>> STAGE);
         z_in = in_z + atan_entry(IDX);
         vx_in = in_vx - (in_vy >>> STAGE);
         vy_in = in_vy + (in_vx >>> STAGE);
      end else begin
         x_in = in_x - (in_y >>> STAGE);
         y_in = in_y + (in_x >>> STAGE);
         z_in = in_z - atan_entry(IDX);
         vx_in = in_vx + (in_vy >>> STAGE);
         vy_in = in_vy - (in_vx >>> STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_z = z_ff;
   assign out_vx = vx_ff;
   assign out_vy = vy_ff;
   assign out_side = side_ff;
endmodule
`default_nettype wire

@@ rtl/core/target_bearing_velocity_command_top.sv @@
// Top level of the target bearing velocity command block.
// Depends on tbvc_pkg, tbvc_if and tbvc_cordic_stage.
`timescale 1ns / 1ps
`default_nettype none
// Takes one position beat per cycle while the response side does not stall and
// returns one command beat per beat, in order. The stages are an offset stage,
// a prescale stage, one stage per CORDIC micro-rotation, a rounding stage, a
// turn rate multiply stage and the output register. The pipeline advances
// whenever the output register is empty or being taken, so a stall on the
// response side holds all stages and the request side sees ready low only then.
module target_bearing_velocity_command_top
   import tbvc_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   tbvc_req_if.sink req,
   tbvc_rsp_if.source rsp,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [CFG_ADDR_WIDTH-1:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int PW = (POS_WIDTH < 32) ? POS_WIDTH : 32;
   localparam int DW = PW + 1 + GUARD_BITS + 2;
   localparam int CW = 2 + 16 + 16;
   localparam int NS = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

   logic signed [31:0] target_x_ff, target_y_ff;
   logic [15:0] speed_gain_ff;
   logic signed [15:0] heading_gain_ff;

   wire cfg_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff <= '0;
         target_y_ff <= '0;
         speed_gain_ff <= 16'd256;
         heading_gain_ff <= '0;
      end else if (cfg_wr && csr_paddr[1:0] == 2'b00) begin
         unique case (csr_paddr[3:2])
            REG_TARGET_X: target_x_ff <= csr_pwdata;
            REG_TARGET_Y: target_y_ff <= csr_pwdata;
            REG_SPEED_GAIN: speed_gain_ff <= csr_pwdata[15:0];
            REG_HEADING_GAIN: heading_gain_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[3:2])
         REG_TARGET_X: csr_prdata = target_x_ff;
         REG_TARGET_Y: csr_prdata = target_y_ff;
         REG_SPEED_GAIN: csr_prdata = {16'd0, speed_gain_ff};
         REG_HEADING_GAIN: csr_prdata = {16'd0, heading_gain_ff};
         default: csr_prdata = '0;
      endcase
   end

   logic rsp_valid_ff;
   wire enable = !rsp_valid_ff || rsp.ready;
   assign req.ready = enable;
   wire req_fire = req.valid & enable;

   // Stage 1: offset.
   logic s1_valid_ff;
   logic signed [PW:0] dx_ff, dy_ff;
   logic [15:0] s1_head_ff;
   logic signed [PW-1:0] px, py, tx, ty;
   assign px = req.pos_x[PW-1:0];
   assign py = req.pos_y[PW-1:0];
   assign tx = target_x_ff[PW-1:0];
   assign ty = target_y_ff[PW-1:0];

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (enable) s1_valid_ff <= req_fire;
      if (enable) begin
         dx_ff <= {tx[PW-1], tx} - {px[PW-1], px};
         dy_ff <= {ty[PW-1], ty} - {py[PW-1], py};
         s1_head_ff <= req.heading;
      end
   end

   // Stage 2: fold into right half plane and scale the speed.
   logic s2_valid_ff;
   logic signed [DW-1:0] x0_ff, y0_ff;
   logic signed [34:0] v0_ff;
   logic [CW-1:0] s2_side_ff;
   logic neg2, zero2;
   logic signed [DW-1:0] dxe, dye;
   assign neg2 = dx_ff < 0;
   assign zero2 = (dx_ff == 0) && (dy_ff == 0);
   assign dxe = {{(DW-PW-1-GUARD_BITS){dx_ff[PW]}}, dx_ff, {GUARD_BITS{1'b0}}};
   assign dye = {{(DW-PW-1-GUARD_BITS){dy_ff[PW]}}, dy_ff, {GUARD_BITS{1'b0}}};

   logic [47:0] vmul;
   assign vmul = speed_gain_ff * KINV_Q30;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (enable) s2_valid_ff <= s1_valid_ff;
      if (enable) begin
         x0_ff <= neg2 ? -dxe : dxe;
         y0_ff <= neg2 ? -dye : dye;
         v0_ff <= 35'(vmul >> 14);
         s2_side_ff <= {neg2, zero2, s1_head_ff, heading_gain_ff};
      end
   end

   logic sv [0:NS];
   logic signed [DW-1:0] sx [0:NS];
   logic signed [DW-1:0] sy [0:NS];
   logic [31:0] sz [0:NS];
   logic signed [34:0] svx [0:NS];
   logic signed [34:0] svy [0:NS];
   logic [CW-1:0] sside [0:NS];

   assign sv[0] = s2_valid_ff;
   assign sx[0] = x0_ff;
   assign sy[0] = y0_ff;
   assign sz[0] = '0;
   assign svx[0] = v0_ff;
   assign svy[0] = '0;
   assign sside[0] = s2_side_ff;

   for (genvar g = 0; g < NS; g++) begin : g_stage
      tbvc_cordic_stage #(.STAGE(g), .DW(DW), .CW(CW)) u_stage (
         .clock(clock), .reset(reset), .enable(enable),
         .in_valid(sv[g]), .in_x(sx[g]), .in_y(sy[g]), .in_z(sz[g]),
         .in_vx(svx[g]), .in_vy(svy[g]), .in_side(sside[g]),
         .out_valid(sv[g+1]), .out_x(sx[g+1]), .out_y(sy[g+1]), .out_z(sz[g+1]),
         .out_vx(svx[g+1]), .out_vy(svy[g+1]), .out_side(sside[g+1])
      );
   end

   // Rounding stage.
   logic s3_valid_ff, s3_zero_ff;
   logic signed [15:0] s3_vx_ff, s3_vy_ff, s3_err_ff, s3_hg_ff;
   logic neg3, zero3;
   logic signed [34:0] fvx, fvy;
   logic [31:0] zr;
   logic [15:0] bear, errv;
   assign neg3 = sside[NS][CW-1];
   assign zero3 = sside[NS][CW-2];
   assign fvx = neg3 ? -svx[NS] : svx[NS];
   assign fvy = neg3 ? -svy[NS] : svy[NS];
   assign zr = sz[NS] + 32'h8000;
   assign bear = zero3 ? 16'd0 : zr[31:16];
   assign errv = sside[NS][31:16] - bear;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (enable) s3_valid_ff <= sv[NS];
      if (enable) begin
         s3_zero_ff <= zero3;
         s3_vx_ff <= zero3 ? 16'sd0 : sat16(64'((fvx + 35'sd32768) >>> 16));
         s3_vy_ff <= zero3 ? 16'sd0 : sat16(64'((fvy + 35'sd32768) >>> 16));
         s3_err_ff <= errv;
         s3_hg_ff <= sside[NS][15:0];
      end
   end

   // Turn rate multiply stage.
   logic s4_valid_ff, s4_zero_ff;
   logic signed [15:0] s4_vx_ff, s4_vy_ff;
   logic signed [31:0] s4_p_ff;
   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (enable) s4_valid_ff <= s3_valid_ff;
      if (enable) begin
         s4_zero_ff <= s3_zero_ff;
         s4_vx_ff <= s3_vx_ff;
         s4_vy_ff <= s3_vy_ff;
         s4_p_ff <= s3_hg_ff * s3_err_ff;
      end
   end

   // Output register.
   logic signed [15:0] vx_out_ff, vy_out_ff, tr_out_ff;
   logic at_out_ff;
   logic signed [32:0] pr;
   assign pr = ($signed({s4_p_ff[31], s4_p_ff}) + 33'sd128) >>> 8;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (enable) rsp_valid_ff <= s4_valid_ff;
      if (enable) begin
         vx_out_ff <= s4_vx_ff;
         vy_out_ff <= s4_vy_ff;
         tr_out_ff <= sat16(64'(pr));
         at_out_ff <= s4_zero_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.vel_x = vx_out_ff;
   assign rsp.vel_y = vy_out_ff;
   assign rsp.turn_rate = tr_out_ff;
   assign rsp.at_target = at_out_ff;
endmodule
`default_nettype wire

@@ rtl/core/tbvc_checker.sv @@
// Port-level checker for the target bearing velocity command block.
// Depends on the top level port list; bound below.
`timescale 1ns / 1ps
`default_nettype none
module tbvc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic signed [15:0] rsp_vel_x,
   input wire logic signed [15:0] rsp_vel_y,
   input wire logic rsp_at_target,
   input wire logic csr_pready
);
   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready) else $error("ready during stall");
   a_free_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("ready low with empty output");
   a_target_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_at_target) |-> (rsp_vel_x == 0 && rsp_vel_y == 0))
      else $error("velocity at target");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("beat dropped");
   a_pready: assert property (@(posedge clock) csr_pready) else $error("pready low");
endmodule

bind target_bearing_velocity_command_top tbvc_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_vel_x(rsp.vel_x), .rsp_vel_y(rsp.vel_y),
   .rsp_at_target(rsp.at_target), .csr_pready(csr_pready)
);
`default_nettype wire

@@ test/target_bearing_velocity_command_top_tb.sv @@
// Testbench for the target bearing velocity command block: directed and random
// position beats checked against an internal CORDIC predictor, with APB setup.
// Depends on tbvc_pkg, tbvc_if and the block's RTL.
`timescale 1ns / 1ps
module target_bearing_velocity_command_top_tb;
   import tbvc_pkg::*;

   typedef struct packed {
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] turn_rate;
      logic at_target;
   } command_type;

   localparam int LATENCY = CORDIC_STAGES_DEF + 5;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CFG_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   tbvc_req_if req ();
   tbvc_rsp_if rsp ();

   target_bearing_velocity_command_top i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   logic signed [31:0] target_x_q = 0;
   logic signed [31:0] target_y_q = 0;
   logic [15:0] speed_gain_q = 16'd256;
   logic signed [15:0] heading_gain_q = 0;

   command_type pending_commands[$];
   int error_count = 0;
   int stall_hold = 0;
   bit long_stall_go = 1'b0;
   bit long_stall_seen = 1'b0;

   always #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic longint shift_right(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic command_type predict_command(input logic signed [31:0] px,
                                                   input logic signed [31:0] py,
                                                   input logic [15:0] heading);
      command_type c;
      longint dx, dy, x, y, xs, ys, vx, vy, e, p;
      logic [31:0] z;
      logic [31:0] dirs;
      logic [15:0] bearing, err;
      bit neg;
      begin
         dx = longint'(target_x_q) - longint'(px);
         dy = longint'(target_y_q) - longint'(py);
         bearing = 16'd0;
         c = '0;
         if (dx == 0 && dy == 0) begin
            c.at_target = 1'b1;
         end else begin
            neg = dx < 0;
            x = dx <<< GUARD_BITS;
            y = dy <<< GUARD_BITS;
            if (neg) begin
               x = -x;
               y = -y;
            end
            z = 32'd0;
            dirs = 32'd0;
            for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
               xs = shift_right(x, i);
               ys = shift_right(y, i);
               if (y > 0) begin
                  x = x + ys; y = y - xs; z = z + atan_entry(5'(i)); dirs[i] = 1'b1;
               end else begin
                  x = x - ys; y = y + xs; z = z - atan_entry(5'(i));
               end
            end
            vx = shift_right(longint'(speed_gain_q) * longint'(KINV_Q30), 14);
            vy = 0;
            for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
               xs = shift_right(vx, i);
               ys = shift_right(vy, i);
               if (dirs[i]) begin
                  vx = vx - ys; vy = vy + xs;
               end else begin
                  vx = vx + ys; vy = vy - xs;
               end
            end
            if (neg) begin
               vx = -vx;
               vy = -vy;
            end
            c.vel_x = sat16(shift_right(vx + 32768, 16));
            c.vel_y = sat16(shift_right(vy + 32768, 16));
            z = z + 32'h8000;
            bearing = z[31:16];
         end
         err = heading - bearing;
         e = longint'($signed(err));
         p = longint'(heading_gain_q) * e;
         c.turn_rate = sat16(shift_right(p + 128, 8));
         return c;
      end
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CFG_ADDR_WIDTH'(index) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_TARGET_X: target_x_q = value;
         REG_TARGET_Y: target_y_q = value;
         REG_SPEED_GAIN: speed_gain_q = value[15:0];
         default: heading_gain_q = value[15:0];
      endcase
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      while (pending_commands.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      else if (pick < 95) return $urandom_range(1, 3);
      else return $urandom_range(10, 40);
   endfunction

   task automatic send_fix(input logic [31:0] px, input logic [31:0] py,
                           input logic [15:0] heading, input bit gaps);
      int gap;
      req.valid <= 1'b1;
      req.pos_x <= px;
      req.pos_y <= py;
      req.heading <= heading;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pending_commands.push_back(predict_command(px, py, heading));
      gap = (gaps && $urandom_range(0, 1)) ? gap_length() : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic end_burst();
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      command_type want;
      if (rsp.valid && rsp.ready) begin
         if (pending_commands.size() == 0) begin
            report_mismatch("unexpected beat", 0, 0);
         end else begin
            want = pending_commands.pop_front();
            if (rsp.vel_x !== want.vel_x) report_mismatch("vel_x", rsp.vel_x, want.vel_x);
            if (rsp.vel_y !== want.vel_y) report_mismatch("vel_y", rsp.vel_y, want.vel_y);
            if (rsp.turn_rate !== want.turn_rate)
               report_mismatch("turn_rate", rsp.turn_rate, want.turn_rate);
            if (rsp.at_target !== want.at_target)
               report_mismatch("at_target", rsp.at_target, want.at_target);
         end
      end
   end

   always @(posedge clock) begin
      int pick;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (long_stall_go != long_stall_seen) begin
         rsp.ready <= 1'b0;
         long_stall_seen <= long_stall_go;
         stall_hold <= 300;
      end else if (stall_hold > 0) begin
         rsp.ready <= 1'b0;
         stall_hold <= stall_hold - 1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70) rsp.ready <= 1'b1;
         else if (pick < 98) rsp.ready <= 1'b0;
         else begin
            rsp.ready <= 1'b0;
            stall_hold <= $urandom_range(10, 50);
         end
      end
   end

   task automatic test_registers();
      write_register(REG_TARGET_X, 32'd1000);
      write_register(REG_TARGET_Y, -32'sd500);
      write_register(REG_SPEED_GAIN, 32'd512);
      write_register(REG_HEADING_GAIN, 32'd256);
   endtask

   task automatic test_directed();
      send_fix(32'd1000, -32'sd500, 16'h0000, 1'b0);
      send_fix(32'd1000, -32'sd500, 16'hFFFF, 1'b0);
      send_fix(32'd1000, 32'd0, 16'h4000, 1'b0);
      send_fix(32'd1000, -32'sd1000, 16'hC000, 1'b0);
      send_fix(32'd2000, -32'sd500, 16'h8000, 1'b0);
      send_fix(32'd0, -32'sd500, 16'h7FFF, 1'b0);
      send_fix(32'h7FFFFFFF, 32'h7FFFFFFF, 16'h1234, 1'b0);
      send_fix(32'h80000000, 32'h80000000, 16'hEDCB, 1'b0);
      send_fix(32'h80000000, 32'h7FFFFFFF, 16'h8001, 1'b0);
      send_fix(32'h7FFFFFFF, 32'h80000000, 16'h0001, 1'b0);
      send_fix(32'd1001, -32'sd500, 16'h0000, 1'b0);
      send_fix(32'd999, -32'sd499, 16'h0000, 1'b0);
      end_burst();
      wait_idle();
      write_register(REG_TARGET_X, 32'h7FFFFFFF);
      write_register(REG_TARGET_Y, 32'h80000000);
      write_register(REG_SPEED_GAIN, 32'hFFFF);
      write_register(REG_HEADING_GAIN, 32'h7FFF);
      send_fix(32'h80000000, 32'h7FFFFFFF, 16'h0000, 1'b0);
      send_fix(32'h7FFFFFFF, 32'h80000000, 16'h8000, 1'b0);
      send_fix(32'd0, 32'd0, 16'h8000, 1'b0);
      send_fix(32'd5, 32'd7, 16'h7FFF, 1'b0);
      end_burst();
      wait_idle();
      write_register(REG_SPEED_GAIN, 32'd0);
      write_register(REG_HEADING_GAIN, 32'h8000);
      send_fix(32'd0, 32'd0, 16'h8000, 1'b0);
      send_fix(32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 1'b0);
      send_fix(32'd1, 32'd1, 16'hFFFF, 1'b0);
      end_burst();
      wait_idle();
   endtask

   task automatic test_backpressure();
      long_stall_go = ~long_stall_go;
      for (int i = 0; i < 60; i++)
         send_fix($urandom, $urandom, 16'($urandom), 1'b0);
      end_burst();
      wait_idle();
   endtask

   task automatic test_random(input int count);
      logic [31:0] px, py;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: begin px = $urandom; py = $urandom; end
            1: begin
               px = target_x_q + $signed($urandom_range(0, 2000)) - 1000;
               py = target_y_q + $signed($urandom_range(0, 2000)) - 1000;
            end
            2: begin px = target_x_q; py = target_y_q + $urandom_range(0, 2) - 1; end
            default: begin
               px = target_x_q + ($urandom & 32'h000FFFFF) - 32'h00080000;
               py = target_y_q + ($urandom & 32'h000FFFFF) - 32'h00080000;
            end
         endcase
         send_fix(px, py, 16'($urandom), 1'b1);
      end
      end_burst();
      wait_idle();
   endtask

   task automatic test_settings();
      for (int phase = 0; phase < 6; phase++) begin
         write_register(REG_TARGET_X, $urandom);
         write_register(REG_TARGET_Y, $urandom);
         write_register(REG_SPEED_GAIN, phase == 0 ? 32'd0 : $urandom_range(0, 65535));
         write_register(REG_HEADING_GAIN, $urandom);
         test_random(210);
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.pos_x = '0;
      req.pos_y = '0;
      req.heading = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_registers();
      test_directed();
      test_backpressure();
      test_settings();
      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/tbvc_pkg.sv
rtl/core/tbvc_if.sv
rtl/core/tbvc_cordic_stage.sv
rtl/core/target_bearing_velocity_command_top.sv
rtl/core/tbvc_checker.sv
test/target_bearing_velocity_command_top_tb.sv
